/* rtl/core/tvbb_pkg.sv */
package tvbb_pkg;

  // configuration registers
  localparam int NUM_REGS  = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;

  // Q16.16 limits
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // queue of transformed points between front and back
  localparam int MID_DEPTH = 8;
  localparam int MID_AW    = $clog2(MID_DEPTH);
  localparam int MID_CW    = $clog2(MID_DEPTH + 1);

  // result queue
  localparam int OUT_DEPTH = 2;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic signed [31:0] vertex_w;
    logic               last_vertex;
  } vertex_t;

  typedef struct packed {
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
  } box_t;

  // one transformed vertex: coord[0..2] = x, y, z
  typedef struct packed {
    logic [2:0][31:0] coord;
    logic             last;
  } point_t;

  // point queue status
  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

  // matrix reset: identity rotation, zero translation
  function automatic logic [CFG_W-1:0] cfg_reset(input logic [CFG_IDX_W-1:0] idx);
    logic [CFG_W-1:0] val;
    case (idx)
      3'd0:    val = 64'h0000_0000_0001_0000;
      3'd2:    val = 64'h0001_0000_0000_0000;
      3'd5:    val = 64'h0000_0000_0001_0000;
      default: val = '0;
    endcase
    return val;
  endfunction

  // signed add, saturated to 32 bits
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) return s[32] ? Q_MIN : Q_MAX;
    return $signed(s[31:0]);
  endfunction

  // Q16.16 rescale of a full product: floor shift by 16, then saturate
  function automatic logic signed [31:0] qscale(input logic signed [63:0] p);
    logic [47:0] sh;
    sh = p[63:16];
    if ((&sh[47:31]) || !(|sh[47:31])) return $signed(sh[31:0]);
    return sh[47] ? Q_MIN : Q_MAX;
  endfunction

endpackage

/* rtl/core/tvbb_front.sv */
module tvbb_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  tvbb_pkg::vertex_t                  vertex,
  input  logic                               cfg_we,
  input  logic [tvbb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tvbb_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               pt_pop,
  output logic                               pt_valid,
  output tvbb_pkg::point_t                   pt
);
  import tvbb_pkg::*;

  logic [CFG_W-1:0]   cfg [NUM_REGS];
  logic signed [31:0] m [3][4];
  logic [MID_CW-1:0]  in_use;
  logic               accept;

  logic               v1_valid;
  vertex_t            v1;
  logic signed [31:0] vin [4];

  logic               v2_valid, v2_last;
  logic signed [63:0] prod [3][4];

  logic               v3_valid, v3_last;
  logic signed [31:0] s3_sum [3];
  logic signed [31:0] s3_q2 [3];
  logic signed [31:0] s3_q3 [3];

  logic               v4_valid, v4_last;
  logic signed [31:0] s4_sum [3];
  logic signed [31:0] s4_q3 [3];

  // matrix registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) cfg[i] <= cfg_reset(CFG_IDX_W'(i));
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      cfg[cfg_index] <= cfg_data;
    end
  end

  // unpack entries: even column in low half, odd column in high half
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        m[r][c] = (c % 2 == 1) ? $signed(cfg[CFG_IDX_W'(r * 2 + c / 2)][63:32])
                               : $signed(cfg[CFG_IDX_W'(r * 2 + c / 2)][31:0]);
      end
    end
  end

  // credits: every word in flight has a slot reserved in the point queue
  assign accept = push && !full;
  assign full   = (in_use == MID_CW'(MID_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
    end else begin
      in_use <= in_use + MID_CW'(accept) - MID_CW'(pt_pop);
    end
  end

  // stage 1: capture vertex
  always_ff @(posedge clk) begin
    if (rst) begin
      v1_valid <= 1'b0;
    end else begin
      v1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      v1 <= vertex;
    end
  end

  assign vin[0] = v1.vertex_x;
  assign vin[1] = v1.vertex_y;
  assign vin[2] = v1.vertex_z;
  assign vin[3] = v1.vertex_w;

  // stage 2: twelve exact products
  always_ff @(posedge clk) begin
    if (rst) begin
      v2_valid <= 1'b0;
    end else begin
      v2_valid <= v1_valid;
    end
  end

  always_ff @(posedge clk) begin
    v2_last <= v1.last_vertex;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        prod[r][c] <= 64'(m[r][c]) * 64'(vin[c]);
      end
    end
  end

  // stage 3: rescale, first sum
  always_ff @(posedge clk) begin
    if (rst) begin
      v3_valid <= 1'b0;
    end else begin
      v3_valid <= v2_valid;
    end
  end

  always_ff @(posedge clk) begin
    v3_last <= v2_last;
    for (int r = 0; r < 3; r++) begin
      s3_sum[r] <= sat_add(qscale(prod[r][0]), qscale(prod[r][1]));
      s3_q2[r]  <= qscale(prod[r][2]);
      s3_q3[r]  <= qscale(prod[r][3]);
    end
  end

  // stage 4: add column 2
  always_ff @(posedge clk) begin
    if (rst) begin
      v4_valid <= 1'b0;
    end else begin
      v4_valid <= v3_valid;
    end
  end

  always_ff @(posedge clk) begin
    v4_last <= v3_last;
    for (int r = 0; r < 3; r++) begin
      s4_sum[r] <= sat_add(s3_sum[r], s3_q2[r]);
      s4_q3[r]  <= s3_q3[r];
    end
  end

  // add column 3 on the way into the point queue
  assign pt_valid = v4_valid;

  always_comb begin
    pt.last = v4_last;
    for (int r = 0; r < 3; r++) begin
      pt.coord[r] = sat_add(s4_sum[r], s4_q3[r]);
    end
  end

endmodule

/* rtl/core/tvbb_point_q.sv */
module tvbb_point_q (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  tvbb_pkg::point_t  din,
  input  logic              rd,
  output tvbb_pkg::point_t  dout,
  output tvbb_pkg::q_stat_t stat
);
  import tvbb_pkg::*;

  point_t            mem [MID_DEPTH];
  logic [MID_AW-1:0] wr_ptr, rd_ptr;
  logic [MID_CW-1:0] count;

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= din;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (rd) rd_ptr <= rd_ptr + 1'b1;
      count <= count + MID_CW'(wr) - MID_CW'(rd);
    end
  end

  assign dout           = mem[rd_ptr];
  assign stat.not_empty = (count != '0);
  assign stat.full      = (count == MID_CW'(MID_DEPTH));

endmodule

/* rtl/core/tvbb_back.sv */
module tvbb_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             pt_valid,
  input  tvbb_pkg::point_t pt,
  output logic             pt_pop,
  output logic             empty,
  input  logic             pop,
  output tvbb_pkg::box_t   box
);
  import tvbb_pkg::*;

  logic signed [31:0] run_min [3];
  logic signed [31:0] run_max [3];
  logic signed [31:0] nmin [3];
  logic signed [31:0] nmax [3];

  box_t              obuf [OUT_DEPTH];
  logic [OUT_AW-1:0] owr, ord;
  logic [OUT_CW-1:0] ocount;
  logic              opush, opop;
  box_t              new_box;

  // take a point unless it closes a box and the result queue is full
  assign pt_pop = pt_valid && (!pt.last || (ocount != OUT_CW'(OUT_DEPTH)));
  assign opush  = pt_pop && pt.last;
  assign opop   = pop && !empty;

  // per-axis compare against the running bounds
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nmin[i] = ($signed(pt.coord[i]) < run_min[i]) ? $signed(pt.coord[i]) : run_min[i];
      nmax[i] = ($signed(pt.coord[i]) > run_max[i]) ? $signed(pt.coord[i]) : run_max[i];
    end
  end

  // accumulators, re-armed after each box
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        run_min[i] <= Q_MAX;
        run_max[i] <= Q_MIN;
      end
    end else if (pt_pop) begin
      for (int i = 0; i < 3; i++) begin
        run_min[i] <= pt.last ? Q_MAX : nmin[i];
        run_max[i] <= pt.last ? Q_MIN : nmax[i];
      end
    end
  end

  always_comb begin
    new_box.box_min_x = nmin[0];
    new_box.box_min_y = nmin[1];
    new_box.box_min_z = nmin[2];
    new_box.box_max_x = nmax[0];
    new_box.box_max_y = nmax[1];
    new_box.box_max_z = nmax[2];
  end

  // result queue
  always_ff @(posedge clk) begin
    if (opush) begin
      obuf[owr] <= new_box;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owr    <= '0;
      ord    <= '0;
      ocount <= '0;
    end else begin
      if (opush) owr <= owr + 1'b1;
      if (opop)  ord <= ord + 1'b1;
      ocount <= ocount + OUT_CW'(opush) - OUT_CW'(opop);
    end
  end

  assign empty = (ocount == '0);
  assign box   = obuf[ord];

endmodule

/* rtl/core/transformed_vertex_bounding_box.sv */
// Axis-aligned bounding box of a mesh after a 3x4 affine transform, Q16.16.
//
// Vertex side: a queue input. A word is taken when push is high and full is
// low, one per cycle while full stays low. last_vertex closes the mesh.
// Box side: a queue output. While empty is low the oldest box is on box; it
// is taken when pop is high. One box is produced per vertex marked last.
// Matrix: six 64-bit registers written over cfg_valid/cfg_index/cfg_data;
// cfg_ready is always high, indexes past the last register are dropped.
// Write the matrix only while no vertex is in flight; a write inside a mesh
// applies from the next vertex and leaves the running bounds alone.
//
// A last vertex passes four pipeline stages (capture, multiply, rescale and
// saturating adds), one slot in the point queue and one compare in the
// min/max unit before its box can be popped.
// Throughput: one vertex per cycle while full is low, set by the single
// compare loop of the min/max unit. When pop is held low the two-entry box
// queue fills, the back end stops at the next last vertex, the eight-entry
// point queue fills and full rises; no word is lost.
// Reset: matrix returns to identity, queues empty, bounds re-armed.
module transformed_vertex_bounding_box (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  tvbb_pkg::vertex_t              vertex,
  output logic                           empty,
  input  logic                           pop,
  output tvbb_pkg::box_t                 box,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tvbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tvbb_pkg::CFG_W-1:0]     cfg_data
);
  import tvbb_pkg::*;

  logic    q_push, q_pop;
  point_t  q_din, q_dout;
  q_stat_t q_stat;

  assign cfg_ready = 1'b1;

  tvbb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .vertex    (vertex),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pt_pop    (q_pop),
    .pt_valid  (q_push),
    .pt        (q_din)
  );

  tvbb_point_q u_point_q (
    .clk  (clk),
    .rst  (rst),
    .wr   (q_push),
    .din  (q_din),
    .rd   (q_pop),
    .dout (q_dout),
    .stat (q_stat)
  );

  tvbb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pt_valid (q_stat.not_empty),
    .pt       (q_dout),
    .pt_pop   (q_pop),
    .empty    (empty),
    .pop      (pop),
    .box      (box)
  );

  // credits must keep the point queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_stat.full))
    else $error("point queue written while full");

  // back end only takes what is there
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_stat.not_empty)
    else $error("point queue read while empty");

  // reset leaves both sides idle
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("block not idle after reset");

endmodule
